### sv/dar_pkg.sv
// Shared types, widths, register indexes and reset values for the
// direction autorepeat qualifier. No dependencies.
package dar_pkg;

  localparam int DAR_CHANNELS  = 4;
  localparam int DAR_TIME_BITS = 48;

  localparam int CHAN_W     = 2;
  localparam int ACT_W      = 2;
  localparam int AXIS_W     = 8;
  localparam int RAW_W      = 8;
  localparam int STAMP_W    = 48;
  localparam int DELAY_W    = 24;
  localparam int THR_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 8;

  // raw stick division: numerator is 127*d or 128*d, d < 256
  localparam int NUM_W     = 15;
  localparam int QUO_W     = 8;
  localparam int DIV_STEPS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_DELAY    = 3'd0,
    REG_LOOP_DELAY       = 3'd1,
    REG_DECREASE_STEP    = 3'd2,
    REG_PAD_THRESHOLD    = 3'd3,
    REG_TABLET_THRESHOLD = 3'd4
  } dar_reg_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_LEFT  = 2'd0,
    ACT_RIGHT = 2'd1,
    ACT_UP    = 2'd2,
    ACT_DOWN  = 2'd3
  } dar_act_t;

  localparam logic [DELAY_W-1:0] RST_INITIAL_DELAY = 24'd200000;
  localparam logic [DELAY_W-1:0] RST_LOOP_DELAY    = 24'd30000;
  localparam logic [DELAY_W-1:0] RST_DECREASE_STEP = 24'd300;
  localparam logic [THR_W-1:0]   RST_PAD_THR       = 7'd50;
  localparam logic [THR_W-1:0]   RST_TABLET_THR    = 7'd20;

  // fallback calibration for a bad raw stick calibration
  localparam logic [RAW_W-1:0] CAL_DEF_MIN    = 8'd0;
  localparam logic [RAW_W-1:0] CAL_DEF_MAX    = 8'd64;
  localparam logic [RAW_W-1:0] CAL_DEF_CENTER = 8'd32;

  localparam logic [THR_W-1:0] THR_FULL_SCALE = 7'd127;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [QUO_W-1:0] den;
  } dar_div_req_t;

  typedef struct packed {
    logic busy;
    logic last;
  } dar_div_stat_t;

endpackage

### sv/dar_div.sv
// Iterative restoring divider for the raw stick scaling, DIV_STEPS quotient
// bits per cycle. Depends on dar_pkg.
module dar_div import dar_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  dar_div_req_t  req,
  output dar_div_stat_t stat,
  output logic [QUO_W-1:0] quo
);

  localparam int ITERS = QUO_W / DIV_STEPS;
  localparam int CNT_W = (ITERS > 1) ? $clog2(ITERS) : 1;

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [QUO_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] low_r, low_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [QUO_W-1:0] den_r;
  logic             last;

  // quotient is known to fit QUO_W bits, so the upper numerator bits
  // already form a remainder below the divisor
  always_comb begin
    logic [QUO_W:0] t;
    rem_nxt = rem_r;
    low_nxt = low_r;
    quo_nxt = quo_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t       = {rem_nxt, low_nxt[QUO_W-1]};
      low_nxt = {low_nxt[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        rem_nxt = QUO_W'(t - {1'b0, den_r});
        quo_nxt = {quo_nxt[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = t[QUO_W-1:0];
        quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign last      = busy_r && (cnt_r == CNT_W'(ITERS - 1));
  assign stat.busy = busy_r;
  assign stat.last = last;
  assign quo       = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= QUO_W'(req.num[NUM_W-1:QUO_W]);
      low_r <= req.num[QUO_W-1:0];
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      quo_r <= quo_nxt;
    end
  end

endmodule

### sv/dar_mem.sv
// Per-channel repeat state memory: last fire time and repeat delay, a
// registered read, valid bits so unwritten entries read as zero.
// Depends on dar_pkg.
module dar_mem import dar_pkg::*; #(
  parameter int CHANNELS  = DAR_CHANNELS,
  parameter int TIME_BITS = DAR_TIME_BITS,
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic [TIME_BITS-1:0] rd_time,
  output logic [DELAY_W-1:0]   rd_delay,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [TIME_BITS-1:0] wr_time,
  input  logic [DELAY_W-1:0]   wr_delay
);

  logic [TIME_BITS-1:0] mem_time  [CHANNELS];
  logic [DELAY_W-1:0]   mem_delay [CHANNELS];
  logic [CHANNELS-1:0]  valid_r;

  logic [TIME_BITS-1:0] rd_time_r;
  logic [DELAY_W-1:0]   rd_delay_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_time[wr_idx]  <= wr_time;
      mem_delay[wr_idx] <= wr_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_time_r  <= mem_time[rd_idx];
      rd_delay_r <= mem_delay[rd_idx];
      rd_valid_r <= valid_r[rd_idx];
    end
  end

  assign rd_time  = rd_valid_r ? rd_time_r  : '0;
  assign rd_delay = rd_valid_r ? rd_delay_r : '0;

endmodule

### sv/direction_autorepeat_qualifier.sv
// Direction autorepeat qualifier top level: input/result streams, config
// registers, control sequencer. Depends on dar_pkg, dar_div, dar_mem.
//
// Usage:
//   in_*   : one controller poll per request (channel/action in tuser,
//            buttons, sticks, raw calibration and timestamp in tdata).
//   out_*  : one result per poll, out_tdata[0] = fire.
//   cfg_*  : register writes, taken on any cycle with cfg_wr_en high;
//            write only while no poll is in flight.
// Sequence: a poll passes through the accept step, which issues the state
//   memory read and loads the divider, the raw stick divider iterations
//   (4 quotient bits each), and the update step, which decides and writes
//   the channel entry back on a fire. A new poll is taken only once the
//   current one has left the update step.
// in_tready is high whenever no poll is in flight, even while a result
//   waits in the output register. If the receiver stalls, the next poll
//   holds in the update cycle until the output register frees up; the
//   state write happens together with the result load, so nothing repeats.
// Reset (rst_n low, synchronous) empties the pipeline, restores register
//   defaults and marks every channel entry as zero via valid bits.
module direction_autorepeat_qualifier import dar_pkg::*; #(
  parameter int CHANNELS  = DAR_CHANNELS,
  parameter int TIME_BITS = DAR_TIME_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata from bit 0: btn_new, btn_held, pad_axis[7:0], tablet_axis[7:0],
  // raw_present, raw_pos[7:0], raw_min[7:0], raw_max[7:0], raw_center[7:0],
  // timestamp_us[47:0], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser from bit 0: channel[1:0], action[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata from bit 0: fire, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_UPD} state_t;
  typedef enum logic [2:0] {RAW_ZERO, RAW_MAX, RAW_MIN, RAW_POS, RAW_NEG} raw_kind_t;

  // configuration registers
  logic [DELAY_W-1:0] init_delay_r, loop_delay_r, step_r;
  logic [THR_W-1:0]   pad_thr_r, tab_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_delay_r <= RST_INITIAL_DELAY;
      loop_delay_r <= RST_LOOP_DELAY;
      step_r       <= RST_DECREASE_STEP;
      pad_thr_r    <= RST_PAD_THR;
      tab_thr_r    <= RST_TABLET_THR;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_INITIAL_DELAY:    init_delay_r <= cfg_wdata[DELAY_W-1:0];
        REG_LOOP_DELAY:       loop_delay_r <= cfg_wdata[DELAY_W-1:0];
        REG_DECREASE_STEP:    step_r       <= cfg_wdata[DELAY_W-1:0];
        REG_PAD_THRESHOLD:    pad_thr_r    <= cfg_wdata[THR_W-1:0];
        REG_TABLET_THRESHOLD: tab_thr_r    <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // input field unpack
  logic [CHAN_W-1:0]  f_ch;
  logic [ACT_W-1:0]   f_act;
  logic               f_new, f_held, f_present;
  logic [AXIS_W-1:0]  f_pad, f_tab;
  logic [RAW_W-1:0]   f_pos, f_min, f_max, f_ctr;
  logic [STAMP_W-1:0] f_stamp;

  assign f_ch      = in_tuser[1:0];
  assign f_act     = in_tuser[3:2];
  assign f_new     = in_tdata[0];
  assign f_held    = in_tdata[1];
  assign f_pad     = in_tdata[9:2];
  assign f_tab     = in_tdata[17:10];
  assign f_present = in_tdata[18];
  assign f_pos     = in_tdata[26:19];
  assign f_min     = in_tdata[34:27];
  assign f_max     = in_tdata[42:35];
  assign f_ctr     = in_tdata[50:43];
  assign f_stamp   = in_tdata[98:51];

  state_t state_r, state_nxt;
  logic   accept;
  logic   in_range_c;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign in_range_c = (int'(f_ch) < CHANNELS);

  // raw stick classification and divider operands, from the request itself
  logic [RAW_W-1:0] c_min, c_max, c_ctr, d_pos, d_neg;
  raw_kind_t        kind_c;
  dar_div_req_t     div_req;

  always_comb begin
    if ((f_min >= f_ctr) || (f_max <= f_ctr)) begin
      c_min = CAL_DEF_MIN;
      c_max = CAL_DEF_MAX;
      c_ctr = CAL_DEF_CENTER;
    end else begin
      c_min = f_min;
      c_max = f_max;
      c_ctr = f_ctr;
    end
    d_pos = f_pos - c_ctr;
    d_neg = c_ctr - f_pos;
    if (!f_present)        kind_c = RAW_ZERO;
    else if (f_pos > c_max) kind_c = RAW_MAX;
    else if (f_pos < c_min) kind_c = RAW_MIN;
    else if (f_pos > c_ctr) kind_c = RAW_POS;
    else                    kind_c = RAW_NEG;
    div_req.start = accept;
    if (kind_c == RAW_POS) begin
      // 127*d as 128*d - d
      div_req.num = {d_pos, 7'b0} - NUM_W'(d_pos);
      div_req.den = c_max - c_ctr;
    end else begin
      div_req.num = {d_neg, 7'b0};
      div_req.den = c_ctr - c_min;
    end
  end

  dar_div_stat_t    div_stat;
  logic [QUO_W-1:0] div_quo;

  dar_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // captured request
  logic [ACT_W-1:0]     act_r;
  logic                 new_r, held_r, in_range_r;
  logic [AXIS_W-1:0]    pad_r, tab_r;
  raw_kind_t            kind_r;
  logic [TIME_BITS-1:0] now_r;
  logic [IDX_W-1:0]     idx_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r      <= f_act;
      new_r      <= f_new;
      held_r     <= f_held;
      pad_r      <= f_pad;
      tab_r      <= f_tab;
      kind_r     <= kind_c;
      now_r      <= TIME_BITS'(f_stamp);
      idx_r      <= IDX_W'(f_ch);
      in_range_r <= in_range_c;
    end
  end

  // state memory
  logic [TIME_BITS-1:0] rd_time;
  logic [DELAY_W-1:0]   rd_delay;
  logic                 wr_en;
  logic [TIME_BITS-1:0] wr_time;
  logic [DELAY_W-1:0]   wr_delay;

  dar_mem #(
    .CHANNELS  (CHANNELS),
    .TIME_BITS (TIME_BITS)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept && in_range_c),
    .rd_idx   (IDX_W'(f_ch)),
    .rd_time  (rd_time),
    .rd_delay (rd_delay),
    .wr_en    (wr_en),
    .wr_idx   (idx_r),
    .wr_time  (wr_time),
    .wr_delay (wr_delay)
  );

  // timer checks, done while the divider runs
  logic                 expired_r;
  logic [DELAY_W-1:0]   next_delay_r;
  logic [TIME_BITS-1:0] elapsed;

  assign elapsed = now_r - rd_time;

  always_ff @(posedge clk) begin
    if (state_r == S_DIV) begin
      expired_r <= (elapsed > TIME_BITS'(rd_delay));
      if (rd_delay == init_delay_r) begin
        next_delay_r <= loop_delay_r;
      end else if (rd_delay > step_r) begin
        next_delay_r <= rd_delay - step_r;
      end else begin
        next_delay_r <= rd_delay;
      end
    end
  end

  // direction decision
  logic                     neg_dir, pad_act, tab_act, raw_act, active, fire_c;
  logic signed [AXIS_W:0]   pad_s, tab_s, pthr_s, tthr_s;
  logic                     quo_gt;

  always_comb begin
    neg_dir = (act_r == ACT_LEFT) || (act_r == ACT_DOWN);
    pad_s   = {pad_r[AXIS_W-1], pad_r};
    tab_s   = {tab_r[AXIS_W-1], tab_r};
    pthr_s  = {2'b00, pad_thr_r};
    tthr_s  = {2'b00, tab_thr_r};
    pad_act = neg_dir ? (pad_s < -pthr_s) : (pad_s > pthr_s);
    tab_act = neg_dir ? (tab_s < -tthr_s) : (tab_s > tthr_s);
    quo_gt  = (div_quo > {1'b0, pad_thr_r});
    // raw value compared by magnitude: +q, -q or full scale
    case (kind_r)
      RAW_MAX: raw_act = !neg_dir && (pad_thr_r < THR_FULL_SCALE);
      RAW_MIN: raw_act = neg_dir;
      RAW_POS: raw_act = !neg_dir && quo_gt;
      RAW_NEG: raw_act = neg_dir && quo_gt;
      default: raw_act = 1'b0;
    endcase
    active = in_range_r && (new_r || held_r || pad_act || tab_act || raw_act);
    fire_c = active && (new_r || expired_r);
  end

  // sequencer and output register
  logic out_tvalid_r, out_tvalid_nxt;
  logic out_fire_r, out_fire_nxt;
  logic out_free;

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_fire_nxt   = out_fire_r;
    wr_en          = 1'b0;
    wr_time        = now_r;
    wr_delay       = new_r ? init_delay_r : next_delay_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.last) state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_fire_nxt   = fire_c;
          wr_en          = fire_c;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_fire_r <= out_fire_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_fire_r};

endmodule

### sim/direction_autorepeat_qualifier_tb.sv
// Self-checking testbench for direction_autorepeat_qualifier: directed polls, then
// randomized press/hold sequences over several register settings.
// Depends on dar_pkg and the direction_autorepeat_qualifier RTL.
module direction_autorepeat_qualifier_tb;
  import dar_pkg::*;

  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [CHAN_W-1:0]        chan;
    dar_act_t                 act;
    logic                     btn_new;
    logic                     btn_held;
    logic signed [AXIS_W-1:0] pad;
    logic signed [AXIS_W-1:0] tab;
    logic                     raw_on;
    logic [RAW_W-1:0]         pos;
    logic [RAW_W-1:0]         mn;
    logic [RAW_W-1:0]         mx;
    logic [RAW_W-1:0]         ct;
    logic [STAMP_W-1:0]       stamp;
  } poll_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // predictor copy of registers and per-channel repeat timers
  logic [DELAY_W-1:0] initial_delay;
  logic [DELAY_W-1:0] loop_delay;
  logic [DELAY_W-1:0] decrease_step;
  logic [THR_W-1:0]   pad_thr;
  logic [THR_W-1:0]   tablet_thr;
  logic [STAMP_W-1:0] fire_stamp [DAR_CHANNELS];
  logic [DELAY_W-1:0] rep_delay [DAR_CHANNELS];

  bit fire_queue [$];
  bit want_fire;
  int errors = 0;
  bit no_idle = 1'b0;
  int quiet_cycles = 0;
  int ready_hold = 0;
  int ready_gap;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  direction_autorepeat_qualifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  function automatic bit is_neg(dar_act_t a);
    return (a == ACT_LEFT) || (a == ACT_DOWN);
  endfunction

  function automatic int raw_level(poll_t p);
    int mn_i, mx_i, ct_i, pos_i, d;
    if (!p.raw_on) return 0;
    mn_i = p.mn;
    mx_i = p.mx;
    ct_i = p.ct;
    pos_i = p.pos;
    if (mn_i >= ct_i || mx_i <= ct_i) begin
      mn_i = int'(CAL_DEF_MIN);
      mx_i = int'(CAL_DEF_MAX);
      ct_i = int'(CAL_DEF_CENTER);
    end
    if (pos_i > mx_i) return 127;
    if (pos_i < mn_i) return -128;
    d = pos_i - ct_i;
    if (d > 0) return (127 * d) / (mx_i - ct_i);
    return -((128 * (-d)) / (ct_i - mn_i));
  endfunction

  function automatic bit beyond(int v, int thr, bit neg);
    return neg ? (v < -thr) : (v > thr);
  endfunction

  // decides fire for one poll and advances that channel's timer
  function automatic bit qualify_poll(poll_t p);
    int thr_p, thr_t;
    bit neg, active;
    logic [STAMP_W-1:0] elapsed;
    neg = is_neg(p.act);
    thr_p = pad_thr;
    thr_t = tablet_thr;
    active = p.btn_new || p.btn_held || beyond(int'(p.pad), thr_p, neg) ||
             beyond(raw_level(p), thr_p, neg) || beyond(int'(p.tab), thr_t, neg);
    if (!active) return 1'b0;
    if (p.btn_new) begin
      fire_stamp[p.chan] = p.stamp;
      rep_delay[p.chan] = initial_delay;
      return 1'b1;
    end
    elapsed = p.stamp - fire_stamp[p.chan];
    if (elapsed <= rep_delay[p.chan]) return 1'b0;
    fire_stamp[p.chan] = p.stamp;
    if (rep_delay[p.chan] == initial_delay) rep_delay[p.chan] = loop_delay;
    else if (rep_delay[p.chan] > decrease_step)
      rep_delay[p.chan] = rep_delay[p.chan] - decrease_step;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[STAMP_W-1:0];
  endfunction

  // nothing pressed, sticks centered, raw stick detached
  function automatic poll_t quiet_poll(int chan, dar_act_t act, logic [STAMP_W-1:0] stamp);
    poll_t p;
    p.chan = CHAN_W'(chan);
    p.act = act;
    p.btn_new = 1'b0;
    p.btn_held = 1'b0;
    p.pad = '0;
    p.tab = '0;
    p.raw_on = 1'b0;
    p.pos = $urandom;
    p.mn = $urandom;
    p.mx = $urandom;
    p.ct = $urandom;
    p.stamp = stamp;
    return p;
  endfunction

  // stamped one past the channel's current delay
  function automatic poll_t due_poll(int chan, dar_act_t act);
    poll_t p;
    p = quiet_poll(chan, act, '0);
    p.stamp = fire_stamp[chan] + rep_delay[chan] + 1;
    return p;
  endfunction

  function automatic poll_t raw_poll(dar_act_t act, int pos, int mn, int ct, int mx);
    poll_t p;
    p = due_poll(1, act);
    p.raw_on = 1'b1;
    p.pos = pos;
    p.mn = mn;
    p.ct = ct;
    p.mx = mx;
    return p;
  endfunction

  function automatic logic [AXIS_W-1:0] push_axis(dar_act_t act, int thr);
    int v;
    v = thr + 1 + $urandom_range(0, 10);
    if (v > 128) v = 128;
    if (is_neg(act)) v = -v;
    else if (v > 127) v = 127;
    return v[AXIS_W-1:0];
  endfunction

  function automatic logic [AXIS_W-1:0] inner_axis(int thr);
    int v;
    v = int'($urandom_range(0, 2 * thr)) - thr;
    return v[AXIS_W-1:0];
  endfunction

  // mostly sane calibration with the stick leaning toward the direction
  function automatic void fill_raw(inout poll_t p);
    int c;
    p.raw_on = 1'b1;
    c = $urandom_range(1, 254);
    p.ct = c;
    p.mn = $urandom_range(0, c - 1);
    p.mx = $urandom_range(c + 1, 255);
    if (is_neg(p.act)) p.pos = $urandom_range(0, c);
    else p.pos = $urandom_range(c, 255);
    if ($urandom_range(0, 4) == 0) p.pos = $urandom;
    if ($urandom_range(0, 5) == 0) begin
      p.mn = $urandom;
      p.mx = $urandom;
      p.ct = $urandom;
    end
  endfunction

  function automatic poll_t held_poll(int chan);
    poll_t p;
    logic [STAMP_W-1:0] d;
    logic [DELAY_W-1:0] rd;
    p = quiet_poll(chan, dar_act_t'($urandom_range(0, 3)), '0);
    case ($urandom_range(0, 5))
      0: p.btn_held = 1'b1;
      1: p.pad = push_axis(p.act, pad_thr);
      2: p.tab = push_axis(p.act, tablet_thr);
      3: fill_raw(p);
      4: begin
        // direction released
        p.pad = inner_axis(pad_thr);
        p.tab = inner_axis(tablet_thr);
      end
      default: begin
        p.btn_held = 1'b1;
        p.pad = $urandom;
        p.tab = $urandom;
      end
    endcase
    rd = rep_delay[chan];
    case ($urandom_range(0, 6))
      0: d = rd;
      1: d = rd + 1;
      2: d = (rd == 0) ? '0 : rd - 1;
      3: d = $urandom_range(0, rd);
      4: d = rd + $urandom_range(2, 5000);
      5: d = rand_stamp();
      default: d = rd + 1 + $urandom_range(0, 3);
    endcase
    p.stamp = fire_stamp[chan] + d;
    return p;
  endfunction

  function automatic poll_t press_poll(int chan);
    poll_t p;
    p = quiet_poll(chan, dar_act_t'($urandom_range(0, 3)), '0);
    p.btn_new = 1'b1;
    p.btn_held = $urandom;
    p.pad = $urandom;
    p.tab = $urandom;
    p.raw_on = $urandom;
    if ($urandom_range(0, 3) == 0) p.stamp = rand_stamp();
    else p.stamp = fire_stamp[chan] + $urandom_range(0, 100000);
    return p;
  endfunction

  function automatic poll_t noise_poll();
    poll_t p;
    p = quiet_poll($urandom_range(0, 3), dar_act_t'($urandom_range(0, 3)), rand_stamp());
    p.btn_new = ($urandom_range(0, 7) == 0);
    p.btn_held = $urandom;
    p.pad = $urandom;
    p.tab = $urandom;
    p.raw_on = $urandom;
    return p;
  endfunction

  // one request per poll; prediction is taken at acceptance
  task automatic send_poll(poll_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    // tdata: btn_new, btn_held, pad, tablet, raw_present, raw pos/min/max/center, stamp
    in_tdata <= {5'b0, p.stamp, p.ct, p.mx, p.mn, p.pos, p.raw_on, p.tab, p.pad,
                 p.btn_held, p.btn_new};
    in_tuser <= {p.act, p.chan};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fire_queue.push_back(qualify_poll(p));
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (fire_queue.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_INITIAL_DELAY:    initial_delay = val;
      REG_LOOP_DELAY:       loop_delay = val;
      REG_DECREASE_STEP:    decrease_step = val;
      REG_PAD_THRESHOLD:    pad_thr = val[THR_W-1:0];
      REG_TABLET_THRESHOLD: tablet_thr = val[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(logic [DELAY_W-1:0] init_d, logic [DELAY_W-1:0] loop_d,
                            logic [DELAY_W-1:0] step_d, logic [THR_W-1:0] pt,
                            logic [THR_W-1:0] tt);
    write_reg(REG_INITIAL_DELAY, init_d);
    write_reg(REG_LOOP_DELAY, loop_d);
    write_reg(REG_DECREASE_STEP, step_d);
    // upper bits are don't-care for the thresholds
    write_reg(REG_PAD_THRESHOLD, {17'($urandom), pt});
    write_reg(REG_TABLET_THRESHOLD, {17'($urandom), tt});
  endtask

  task automatic random_phase(int n);
    int r, ch;
    poll_t p;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      ch = $urandom_range(0, DAR_CHANNELS - 1);
      if (r < 12) p = noise_poll();
      else if (r < 24) p = press_poll(ch);
      else p = held_poll(ch);
      send_poll(p);
      if ($urandom_range(0, 199) == 0) wait_drain();
    end
    wait_drain();
  endtask

  // held with no prior press compares against a zero delay
  task automatic test_held_from_reset();
    poll_t p;
    p = quiet_poll(0, ACT_RIGHT, '0);
    p.btn_held = 1'b1;
    send_poll(p);
    p.stamp = 1;
    send_poll(p);
    p = due_poll(0, ACT_DOWN);
    p.btn_held = 1'b1;
    send_poll(p);
  endtask

  task automatic test_press_repeat();
    poll_t p;
    p = quiet_poll(2, ACT_UP, 48'h1000);
    p.btn_new = 1'b1;
    send_poll(p);
    for (int k = 0; k < 5; k++) begin
      p = due_poll(2, ACT_UP);
      p.btn_held = 1'b1;
      // exactly at the delay must not fire
      if (k == 1 || k == 3) p.stamp = p.stamp - 1;
      send_poll(p);
    end
  endtask

  task automatic test_stick_thresholds();
    poll_t p;
    dar_act_t a;
    int t;
    for (int k = 0; k < 4; k++) begin
      a = dar_act_t'(k);
      t = pad_thr;
      p = due_poll(3, a);
      p.pad = is_neg(a) ? -t : t;
      send_poll(p);
      p = due_poll(3, a);
      p.pad = is_neg(a) ? -(t + 1) : t + 1;
      send_poll(p);
    end
    t = tablet_thr;
    p = due_poll(3, ACT_LEFT);
    p.tab = -(t + 1);
    send_poll(p);
    p = due_poll(3, ACT_LEFT);
    p.pad = -128;
    send_poll(p);
    p = due_poll(3, ACT_RIGHT);
    p.pad = 127;
    send_poll(p);
  endtask

  task automatic test_raw_stick();
    poll_t p;
    send_poll(raw_poll(ACT_RIGHT, 150, 0, 100, 200));
    send_poll(raw_poll(ACT_RIGHT, 140, 0, 100, 200));
    send_poll(raw_poll(ACT_UP, 201, 0, 100, 200));
    send_poll(raw_poll(ACT_LEFT, 5, 10, 100, 200));
    // min equal to center falls back to the default calibration
    send_poll(raw_poll(ACT_DOWN, 10, 100, 100, 200));
    p = raw_poll(ACT_LEFT, 0, 10, 100, 200);
    p.raw_on = 1'b0;
    send_poll(p);
  endtask

  task automatic test_time_wrap();
    poll_t p;
    p = quiet_poll(0, ACT_LEFT, 48'hFFFF_FFFF_FFF0);
    p.btn_new = 1'b1;
    send_poll(p);
    p = due_poll(0, ACT_LEFT);
    p.btn_held = 1'b1;
    p.stamp = p.stamp - 1;
    send_poll(p);
    p.stamp = p.stamp + 1;
    send_poll(p);
  endtask

  task automatic test_setting_sweep();
    random_phase(200);
    set_config('0, '0, '0, '0, '0);
    random_phase(200);
    set_config('1, '1, '1, '1, '1);
    random_phase(200);
    set_config(1000, 100, 30, $urandom, $urandom);
    random_phase(300);
    // loop delay equal to the initial delay, no shrink
    set_config(500, 500, 0, $urandom, $urandom);
    random_phase(200);
    // step larger than the loop delay
    set_config(50, 400, 600, $urandom, $urandom);
    random_phase(200);
  endtask

  task automatic test_unknown_index();
    for (int k = int'(REG_TABLET_THRESHOLD) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    random_phase(200);
  endtask

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      ready_gap = pick_gap();
      if (ready_gap > 0) begin
        out_tready <= 1'b0;
        ready_hold = ready_gap - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (fire_queue.size() == 0) begin
        errors++;
        $display("%0t: result with no poll pending, tdata %h", $time, out_tdata);
      end else begin
        want_fire = fire_queue.pop_front();
        if (out_tdata !== OUT_TDATA_W'(want_fire)) begin
          errors++;
          $display("%0t: fire mismatch: expected %h, actual %h", $time,
                   OUT_TDATA_W'(want_fire), out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL direction_autorepeat_qualifier");
        $finish;
      end
    end
  end

  initial begin
    initial_delay = RST_INITIAL_DELAY;
    loop_delay = RST_LOOP_DELAY;
    decrease_step = RST_DECREASE_STEP;
    pad_thr = RST_PAD_THR;
    tablet_thr = RST_TABLET_THR;
    for (int k = 0; k < DAR_CHANNELS; k++) begin
      fire_stamp[k] = '0;
      rep_delay[k] = '0;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_held_from_reset();
    test_press_repeat();
    test_stick_thresholds();
    test_raw_stick();
    test_time_wrap();
    wait_drain();
    test_setting_sweep();
    test_unknown_index();

    wait_drain();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("PASS direction_autorepeat_qualifier");
    else $display("FAIL direction_autorepeat_qualifier");
    $finish;
  end

endmodule
